@@ design/ssrch_pkg.sv @@
// Shared types, constants and helpers for the streaming substring search block.
package ssrch_pkg;

  localparam int MAX_NEEDLE_DEF   = 16;
  localparam int MAX_HAYSTACK_DEF = 65536;
  localparam int NEEDLE_REG_BYTES = 16;
  localparam int START_W          = 16;
  localparam int LEN_W            = 5;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
    logic               too_long;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0]      len;
    logic [CFG_DATA_W-1:0] high;
    logic [CFG_DATA_W-1:0] low;
  } needle_cfg_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

  // Needle byte j; bytes past the two registers read as zero.
  function automatic logic [7:0] needle_byte(input needle_cfg_t cfg, input logic [LEN_W-1:0] j);
    logic [2*CFG_DATA_W-1:0] both;
    both = {cfg.high, cfg.low};
    if (j < LEN_W'(NEEDLE_REG_BYTES)) begin
      return both[j[3:0]*8 +: 8];
    end
    return 8'd0;
  endfunction

endpackage

@@ design/streaming_substring_search_top.sv @@
// Streaming substring search: byte window chain, match control and result register.
// A result is registered and presented on out_valid in the cycle after the beat that causes it.
// Throughput: one byte beat per cycle; in_ready drops only while a held result is stalled.
// The window cells compare all needle positions in parallel in the accepting cycle.
// Reset (rst_n low, synchronous) clears the needle registers, window, count and flags.
module streaming_substring_search_top
  import ssrch_pkg::*;
#(
  parameter int MAX_NEEDLE   = MAX_NEEDLE_DEF,
  parameter int MAX_HAYSTACK = MAX_HAYSTACK_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_HAYSTACK + 1);

  needle_cfg_t cfg_r, cfg_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic reported_r, reported_nxt;
  logic sat_r, sat_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic accept, sat_now, advance, len_ok, cnt_ok, all_hit, match, emit_nf;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] start_diff;
  cell_ctrl_t cell_ctrl;
  logic [7:0] chain [MAX_NEEDLE+1];
  logic [MAX_NEEDLE-1:0] hits;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEEDLE_LOW:  cfg_nxt.low  = cfg_wdata;
        CFG_NEEDLE_HIGH: cfg_nxt.high = cfg_wdata;
        CFG_NEEDLE_LEN:  cfg_nxt.len  = cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign sat_now   = count_r == CNT_W'(MAX_HAYSTACK);
  assign advance   = accept && !sat_now;
  assign count_inc = count_r + CNT_W'(1);

  assign cell_ctrl.advance = advance;
  assign cell_ctrl.clear   = accept && in_data.last;

  assign chain[0] = in_data.data_byte;

  for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
    ssrch_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cell_ctrl),
      .cfg     (cfg_r),
      .shift_in(chain[i]),
      .byte_q  (chain[i+1]),
      .hit     (hits[i])
    );
  end

  assign all_hit    = &hits;
  assign len_ok     = (cfg_r.len != '0) && ({2'b00, cfg_r.len} <= 7'(MAX_NEEDLE));
  assign cnt_ok     = count_inc >= CNT_W'(cfg_r.len);
  assign match      = advance && !reported_r && len_ok && cnt_ok && all_hit;
  assign emit_nf    = accept && in_data.last && !reported_r && !match;
  assign start_diff = count_inc - CNT_W'(cfg_r.len);

  always_comb begin
    count_nxt    = count_r;
    reported_nxt = reported_r;
    sat_nxt      = sat_r;
    if (accept) begin
      if (in_data.last) begin
        count_nxt    = '0;
        reported_nxt = 1'b0;
        sat_nxt      = 1'b0;
      end else if (sat_now) begin
        sat_nxt = 1'b1;
      end else begin
        count_nxt    = count_inc;
        reported_nxt = reported_r || match;
      end
    end
  end

  // The result register holds a beat until taken; a new result may load as it leaves.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (match) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.found       = 1'b1;
      out_data_nxt.match_start = START_W'(start_diff);
      out_data_nxt.too_long    = 1'b0;
    end else if (emit_nf) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.found       = 1'b0;
      out_data_nxt.match_start = '0;
      out_data_nxt.too_long    = sat_r || sat_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      count_r     <= '0;
      reported_r  <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      count_r     <= count_nxt;
      reported_r  <= reported_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/ssrch_cell.sv @@
// One window cell: holds one haystack byte and checks the incoming byte against its needle byte.
module ssrch_cell
  import ssrch_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_ctrl_t  ctrl,
  input  needle_cfg_t cfg,
  input  logic [7:0]  shift_in,
  output logic [7:0]  byte_q,
  output logic        hit
);

  logic [7:0]       byte_r;
  logic [7:0]       byte_nxt;
  logic [6:0]       len_ext;
  logic             in_use;
  logic [LEN_W-1:0] sel;

  // After the shift this cell holds shift_in; it lines up with needle byte len-1-IDX.
  assign len_ext = {2'b00, cfg.len};
  assign in_use  = len_ext > 7'(IDX);
  assign sel     = LEN_W'(len_ext - 7'(IDX) - 7'd1);
  assign hit     = !in_use || (shift_in == needle_byte(cfg, sel));

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clear) begin
      byte_nxt = 8'd0;
    end else if (ctrl.advance) begin
      byte_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_q = byte_r;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the streaming substring search block.
module tb_top;
  import ssrch_pkg::*;

  // The slowest correct run is about 800 beats with random idle gaps around each,
  // plus a short drain before every group of register writes.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BEATS = 550;
  localparam int SETTLE       = 4;

  typedef enum logic [1:0] {ROW_BEAT, ROW_REPORT, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    in_t                   beat;
    out_t                  report;
  } row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the needle registers and the per-haystack state.
  logic [CFG_DATA_W-1:0] nd_low  = '0;
  logic [CFG_DATA_W-1:0] nd_high = '0;
  logic [LEN_W-1:0]      nd_len  = '0;
  logic [7:0]            hay_window [MAX_NEEDLE_DEF];
  int unsigned           hay_count;
  bit                    hay_reported;
  bit                    hay_saturated;

  out_t        expected_reports [$];
  row_t        script [$];
  int          errors     = 0;
  int unsigned cycles     = 0;
  int unsigned beats_sent = 0;
  int          rx_wait    = 0;
  bit          no_gaps    = 1'b0;

  streaming_substring_search_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void restart_haystack();
    foreach (hay_window[k]) hay_window[k] = 8'h00;
    hay_count     = 0;
    hay_reported  = 1'b0;
    hay_saturated = 1'b0;
  endfunction

  function automatic logic [7:0] pattern_at(input int j);
    logic [2*CFG_DATA_W-1:0] both;
    both = {nd_high, nd_low};
    return both[j*8 +: 8];
  endfunction

  // Advances the search state by one haystack byte; returns 1 when a result is due.
  function automatic bit search_step(input in_t beat, output out_t res);
    bit hit;
    bit produced;
    int j;
    produced = 1'b0;
    res      = '0;
    if (hay_count >= MAX_HAYSTACK_DEF) begin
      hay_saturated = 1'b1;
    end else begin
      for (j = MAX_NEEDLE_DEF - 1; j > 0; j--) hay_window[j] = hay_window[j-1];
      hay_window[0] = beat.data_byte;
      hay_count++;
      if (!hay_reported && nd_len != 0 && nd_len <= MAX_NEEDLE_DEF && hay_count >= nd_len) begin
        hit = 1'b1;
        for (j = 0; j < nd_len; j++) begin
          if (hay_window[nd_len-1-j] != pattern_at(j)) hit = 1'b0;
        end
        if (hit) begin
          hay_reported    = 1'b1;
          res.found       = 1'b1;
          res.match_start = START_W'(hay_count - nd_len);
          res.too_long    = hay_saturated;
          produced        = 1'b1;
        end
      end
    end
    if (beat.last) begin
      if (!hay_reported) begin
        res          = '0;
        res.too_long = hay_saturated;
        produced     = 1'b1;
      end
      restart_haystack();
    end
    return produced;
  endfunction

  function automatic row_t mk_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    row_t row;
    row         = '0;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.wdata   = val;
    return row;
  endfunction

  function automatic row_t mk_beat(input logic [7:0] b, input logic last);
    row_t row;
    row                = '0;
    row.kind           = ROW_BEAT;
    row.beat.data_byte = b;
    row.beat.last      = last;
    return row;
  endfunction

  function automatic row_t mk_report(input logic [7:0] b, input logic last,
                                     input logic found, input logic [START_W-1:0] start);
    row_t row;
    row                    = mk_beat(b, last);
    row.kind               = ROW_REPORT;
    row.report.found       = found;
    row.report.match_start = start;
    row.report.too_long    = 1'b0;
    return row;
  endfunction

  // Valid is only lowered when a gap follows, so a back-to-back beat keeps it high.
  task automatic send_beat(input in_t beat, input bit typed, input out_t typed_rep);
    int   gap;
    out_t predicted;
    bit   produced;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    produced = search_step(beat, predicted);
    if (typed) begin
      expected_reports.push_back(typed_rep);
    end else if (produced) begin
      expected_reports.push_back(predicted);
    end
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NEEDLE_LOW:  nd_low  = val;
      CFG_NEEDLE_HIGH: nd_high = val;
      CFG_NEEDLE_LEN:  nd_len  = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Filler is drawn half the time from the needle's own bytes to provoke partial matches.
  task automatic send_haystack(input int hay_len, input int plant_at, input int flip_at);
    in_t beat;
    int  span;
    int  k;
    int  rel;
    span = (nd_len > MAX_NEEDLE_DEF) ? 0 : int'(nd_len);
    for (k = 0; k < hay_len; k++) begin
      rel = k - plant_at;
      if (plant_at >= 0 && rel >= 0 && rel < span) begin
        beat.data_byte = pattern_at(rel);
      end else if (span != 0 && $urandom_range(0, 1) == 1) begin
        beat.data_byte = pattern_at($urandom_range(0, span - 1));
      end else begin
        beat.data_byte = 8'($urandom);
      end
      if (k == flip_at) beat.data_byte ^= 8'(1 << $urandom_range(0, 7));
      beat.last = (k == hay_len - 1);
      send_beat(beat, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got found=%0d match_start=%0d too_long=%0d",
                 $time, out_data.found, out_data.match_start, out_data.too_long);
      end else begin
        want = expected_reports.pop_front();
        if (out_data.found !== want.found) begin
          errors++;
          $display("%0t: found expected %0d, got %0d", $time, want.found, out_data.found);
        end
        if (out_data.match_start !== want.match_start) begin
          errors++;
          $display("%0t: match_start expected %0d, got %0d",
                   $time, want.match_start, out_data.match_start);
        end
        if (out_data.too_long !== want.too_long) begin
          errors++;
          $display("%0t: too_long expected %0d, got %0d", $time, want.too_long, out_data.too_long);
        end
      end
      rx_wait = no_gaps ? 0 : $urandom_range(0, 14);
    end
  end

  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[streaming_substring_search_top] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int                    k;
    int                    pick;
    int                    len_pick;
    int                    hay_len;
    int                    plant_at;
    int                    flip_at;
    logic [CFG_DATA_W-1:0] wide;
    logic [127:0]          full_needle;

    restart_haystack();
    full_needle = 128'hFFEE_DDCC_BBAA_9988_0706_0504_0302_01FF;

    // A zero needle length never matches, so the last byte reports not found.
    script.push_back(mk_report(8'h00, 1'b1, 1'b0, 16'd0));
    script.push_back(mk_write(CFG_NEEDLE_LOW, 64'h0000_0000_0000_FF00));
    script.push_back(mk_write(CFG_NEEDLE_LEN, 64'd2));
    script.push_back(mk_beat(8'h00, 1'b0));
    script.push_back(mk_report(8'hFF, 1'b0, 1'b1, 16'd0));
    script.push_back(mk_beat(8'h55, 1'b1));
    // A length beyond the window never matches.
    script.push_back(mk_write(CFG_NEEDLE_LEN, 64'd31));
    script.push_back(mk_report(8'hFF, 1'b1, 1'b0, 16'd0));
    // The window keeps AB across the change of needle in mid-haystack.
    script.push_back(mk_write(CFG_NEEDLE_LEN, 64'd16));
    script.push_back(mk_beat(8'hAB, 1'b0));
    script.push_back(mk_write(CFG_NEEDLE_LOW, 64'h0000_0000_0000_CDAB));
    script.push_back(mk_write(CFG_NEEDLE_LEN, 64'd2));
    script.push_back(mk_report(8'hCD, 1'b0, 1'b1, 16'd0));
    script.push_back(mk_beat(8'h00, 1'b1));
    // Full-width needle, matched on the last beat of the haystack.
    script.push_back(mk_write(CFG_NEEDLE_LOW, full_needle[63:0]));
    script.push_back(mk_write(CFG_NEEDLE_HIGH, full_needle[127:64]));
    script.push_back(mk_write(CFG_NEEDLE_LEN, 64'd16));
    script.push_back(mk_beat(8'h5A, 1'b0));
    for (k = 0; k < 15; k++) script.push_back(mk_beat(full_needle[k*8 +: 8], 1'b0));
    script.push_back(mk_report(full_needle[127:120], 1'b1, 1'b1, 16'd1));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      if (script[r].kind == ROW_WRITE) begin
        if (r == 0 || script[r-1].kind != ROW_WRITE) drain();
        write_reg(script[r].reg_idx, script[r].wdata);
      end else begin
        send_beat(script[r].beat, script[r].kind == ROW_REPORT, script[r].report);
      end
    end

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      drain();
      no_gaps = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 19);
      if (pick == 0) begin
        len_pick = 0;
      end else if (pick <= 3) begin
        len_pick = 16;
      end else if (pick == 4) begin
        len_pick = $urandom_range(17, 31);
      end else begin
        len_pick = $urandom_range(1, 15);
      end
      wide = {$urandom, $urandom};
      write_reg(CFG_NEEDLE_LOW, {$urandom, $urandom});
      write_reg(CFG_NEEDLE_HIGH, {$urandom, $urandom});
      write_reg(CFG_NEEDLE_LEN, {wide[CFG_DATA_W-1:LEN_W], LEN_W'(len_pick)});
      repeat ($urandom_range(1, 4)) begin
        hay_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 24);
        if ($urandom_range(0, 9) < 7) begin
          plant_at = $urandom_range(0, hay_len - 1);
          flip_at  = ($urandom_range(0, 3) == 0) ? plant_at + $urandom_range(0, 15) : -1;
        end else begin
          plant_at = -1;
          flip_at  = -1;
        end
        send_haystack(hay_len, plant_at, flip_at);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[streaming_substring_search_top] OK");
    end else begin
      $display("[streaming_substring_search_top] ERROR");
    end
    $finish;
  end

endmodule
